// File: hdl/rle_texture_decoder_argb_top_assert.svh
// ----------------------------------------------------------------------------
// RLE texture decoder assertion macros
// Shared property shorthands, all clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef RLE_TEXTURE_DECODER_ARGB_TOP_ASSERT_SVH
`define RLE_TEXTURE_DECODER_ARGB_TOP_ASSERT_SVH

// same-cycle implication
`define RTDA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RTDA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/rtda_pkg.sv
// ----------------------------------------------------------------------------
// RLE texture decoder package
// Transfer types, codes, constants and the pixel expansion function.
// ----------------------------------------------------------------------------
package rtda_pkg;

    // fixed field widths
    localparam int TOTAL_W   = 25;
    localparam int MAX_EMIT  = 64;
    localparam int RUN_CNT_W = $clog2(MAX_EMIT + 1);

    // command codes
    localparam logic [7:0] CMD_SINGLE = 8'd0;
    localparam logic [7:0] RUN_MIN    = 8'd2;
    localparam logic [7:0] RUN_MAX    = 8'd250;

    // register indexes
    localparam logic REG_FORMAT = 1'b0;
    localparam logic REG_TOTAL  = 1'b1;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 25'd65536;

    typedef enum logic [1:0] {
        ERR_OK         = 2'd0,
        ERR_BAD_CMD    = 2'd1,
        ERR_CLIPPED    = 2'd2,
        ERR_AFTER_DONE = 2'd3
    } err_t;

    typedef struct packed {
        logic        first_of_image;
        logic [7:0]  run_command;
        logic [15:0] pixel_word;
    } rec_item_t;

    typedef struct packed {
        logic [31:0] pixel_argb;
        logic        pixel_valid;
        logic        last_of_run;
        logic        image_done;
        err_t        error_code;
    } pix_item_t;

    // controller to datapath
    typedef struct packed {
        logic take_record;
        logic emit_pixel;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic rec_error;
        logic run_last;
    } dp_status_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // widen a 16-bit packed pixel to ARGB8888
    function automatic logic [31:0] expand_pixel(input logic fmt_4444,
                                                 input logic [15:0] n);
        logic [7:0] a;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        if (fmt_4444)
        begin
            a = {n[15:12], n[15:12]};
            r = {n[11:8], n[11:8]};
            g = {n[7:4], n[7:4]};
            b = {n[3:0], n[3:0]};
        end
        else
        begin
            a = n[15] ? 8'hff : 8'h00;
            r = {n[14:10], n[14:12]};
            g = {n[9:5], n[9:7]};
            b = {n[4:0], n[4:2]};
        end
        return {a, r, g, b};
    endfunction

endpackage

// File: hdl/rtda_ctrl.sv
// ----------------------------------------------------------------------------
// RLE texture decoder controller
// Sequences record intake and per-pixel emission of a run.
// ----------------------------------------------------------------------------
module rtda_ctrl
    import rtda_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rec_valid,
    output logic       rec_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (rec_valid && status.out_free && !status.rec_error)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (status.out_free && status.run_last)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        rec_stall       = 1'b1;
        cmd.take_record = 1'b0;
        cmd.emit_pixel  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                rec_stall       = !status.out_free;
                cmd.take_record = rec_valid && status.out_free;
            end
            ST_RUN:
            begin
                cmd.emit_pixel = status.out_free;
            end
            default: rec_stall = 1'b1;
        endcase
    end

endmodule

// File: hdl/rtda_datapath.sv
// ----------------------------------------------------------------------------
// RLE texture decoder datapath
// Pixel counter, run counter, ARGB expansion and the output register.
// ----------------------------------------------------------------------------
module rtda_datapath
    import rtda_pkg::*;
#(
    parameter int COUNT_WIDTH = 25
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               format_is_4444,
    input  logic [TOTAL_W-1:0] pixel_total,
    input  rec_item_t          rec,
    input  ctrl_cmd_t          cmd,
    output dp_status_t         status,
    output logic               pix_valid,
    input  logic               pix_stall,
    output pix_item_t          pix
);

    logic [COUNT_WIDTH-1:0] left_reg;
    logic [COUNT_WIDTH-1:0] left_next;
    logic [RUN_CNT_W-1:0]   run_reg;
    logic [RUN_CNT_W-1:0]   run_next;
    logic                   clip_reg;
    logic                   clip_next;
    logic [31:0]            argb_reg;
    logic [31:0]            argb_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    pix_item_t              pix_reg;
    pix_item_t              pix_next;

    // record decode
    logic [COUNT_WIDTH-1:0] left_eff;
    logic [7:0]             run8;
    logic [7:0]             run_a;
    logic                   cmd_ok;
    logic                   over_left;
    logic                   over_max;
    logic                   rec_done;

    always_comb
    begin
        left_eff  = rec.first_of_image ? COUNT_WIDTH'(pixel_total) : left_reg;
        rec_done  = (left_eff == '0);
        cmd_ok    = (rec.run_command == CMD_SINGLE) ||
                    (rec.run_command inside {[RUN_MIN:RUN_MAX]});
        run8      = (rec.run_command == CMD_SINGLE) ? 8'd1 : rec.run_command;
        over_left = (COUNT_WIDTH'(run8) > left_eff);
        run_a     = over_left ? left_eff[7:0] : run8;
        over_max  = (run_a > 8'(MAX_EMIT));
    end

    // status to controller
    always_comb
    begin
        status.out_free  = !out_valid_reg || !pix_stall;
        status.rec_error = rec_done || !cmd_ok;
        status.run_last  = (run_reg == RUN_CNT_W'(1));
    end

    // next values
    always_comb
    begin
        left_next      = left_reg;
        run_next       = run_reg;
        clip_next      = clip_reg;
        argb_next      = argb_reg;
        pix_next       = pix_reg;
        out_valid_next = out_valid_reg && pix_stall;

        if (cmd.take_record)
        begin
            left_next = left_eff;
            if (rec_done || !cmd_ok)
            begin
                pix_next.pixel_argb  = '0;
                pix_next.pixel_valid = 1'b0;
                pix_next.last_of_run = 1'b1;
                pix_next.image_done  = 1'b0;
                pix_next.error_code  = rec_done ? ERR_AFTER_DONE : ERR_BAD_CMD;
                out_valid_next       = 1'b1;
            end
            else
            begin
                run_next  = over_max ? RUN_CNT_W'(MAX_EMIT) : run_a[RUN_CNT_W-1:0];
                clip_next = over_left || over_max;
                argb_next = expand_pixel(format_is_4444, rec.pixel_word);
            end
        end
        else if (cmd.emit_pixel)
        begin
            left_next            = left_reg - COUNT_WIDTH'(1);
            run_next             = run_reg - RUN_CNT_W'(1);
            pix_next.pixel_argb  = argb_reg;
            pix_next.pixel_valid = 1'b1;
            pix_next.last_of_run = status.run_last;
            pix_next.image_done  = (left_reg == COUNT_WIDTH'(1));
            pix_next.error_code  = (status.run_last && clip_reg) ? ERR_CLIPPED : ERR_OK;
            out_valid_next       = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            run_reg       <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg      <= left_next;
            run_reg       <= run_next;
            clip_reg      <= clip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        argb_reg <= argb_next;
        pix_reg  <= pix_next;
    end

    assign pix_valid = out_valid_reg;
    assign pix       = pix_reg;

endmodule

// File: hdl/rle_texture_decoder_argb_top.sv
// ----------------------------------------------------------------------------
// RLE texture decoder, ARGB output
// Expands run-length records of 1555/4444 pixels into ARGB8888 pixels.
// ----------------------------------------------------------------------------
//  channel | signals                    | moves
//  rec     | rec_valid, rec_stall, rec  | one record (first flag, command, pixel)
//  pix     | pix_valid, pix_stall, pix  | one result (pixel, flags, error code)
//  apb     | psel .. prdata             | format_is_4444 at 0x0, pixel_total at 0x4
//
//  An error record (bad command or image complete) gives one error result.
//  A good record gives N pixels, N = min(run, pixels left, 64): the record
//  loads the run counter, then it emits one pixel per cycle unless pix stalls.
//  Reset clears the pixel counter, so the image must start with first_of_image.
//  A stall on pix holds the output register and the run counter.
// ----------------------------------------------------------------------------
module rle_texture_decoder_argb_top
    import rtda_pkg::*;
#(
    parameter int COUNT_WIDTH = 25
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        rec_valid,
    output logic        rec_stall,
    input  rec_item_t   rec,
    output logic        pix_valid,
    input  logic        pix_stall,
    output pix_item_t   pix
);

    logic               format_reg;
    logic               format_next;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic               cfg_write;
    ctrl_cmd_t          cmd;
    dp_status_t         status;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        format_next = format_reg;
        total_next  = total_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                REG_FORMAT: format_next = pwdata[0];
                REG_TOTAL:  total_next  = pwdata[TOTAL_W-1:0];
                default:    format_next = format_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= 1'b0;
            total_reg  <= TOTAL_RESET;
        end
        else
        begin
            format_reg <= format_next;
            total_reg  <= total_next;
        end
    end

    // register readback
    always_comb
    begin
        case (paddr[2])
            REG_FORMAT: prdata = {31'd0, format_reg};
            REG_TOTAL:  prdata = 32'(total_reg);
            default:    prdata = '0;
        endcase
    end

    rtda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .status    (status),
        .cmd       (cmd)
    );

    rtda_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .format_is_4444 (format_reg),
        .pixel_total    (total_reg),
        .rec            (rec),
        .cmd            (cmd),
        .status         (status),
        .pix_valid      (pix_valid),
        .pix_stall      (pix_stall),
        .pix            (pix)
    );

    // checks
`include "rle_texture_decoder_argb_top_assert.svh"

    `RTDA_ASSERT_IMP(a_no_take_when_blocked, pix_valid && pix_stall, rec_stall,
        "record taken while output register is blocked")
    `RTDA_ASSERT_IMP(a_done_ends_run, pix_valid && pix.image_done,
        pix.last_of_run && pix.pixel_valid, "image_done not on final pixel of a run")
    `RTDA_ASSERT_IMP(a_error_single, pix_valid && !pix.pixel_valid,
        pix.last_of_run && (pix.error_code == ERR_BAD_CMD ||
        pix.error_code == ERR_AFTER_DONE), "error result malformed")
    `RTDA_ASSERT_IMP(a_run_holds_input,
        pix_valid && pix.pixel_valid && !pix.last_of_run, rec_stall,
        "record taken in the middle of a run")
    `RTDA_ASSERT_NXT(a_stalled_pix_held, pix_valid && pix_stall,
        pix_valid && $stable(pix), "stalled pixel transfer changed")

endmodule
